### sv/transducer_focus_phase_macros.svh
`ifndef TRANSDUCER_FOCUS_PHASE_MACROS_SVH
`define TRANSDUCER_FOCUS_PHASE_MACROS_SVH

// check that a condition implies a consequence on every clock edge out of reset
`define TFP_ASSERT_IMPLY(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("implication check failed");

// check that a condition holds on every clock edge out of reset
`define TFP_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`endif

### sv/tfp_pkg.sv
`timescale 1ns / 1ps
package tfp_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int COORD_W       = 24;
   localparam int FREQ_W        = 20;
   localparam int SPEED_W       = 21;
   localparam int ABS_W         = 25;
   localparam int SUMSQ_W       = 50;
   localparam int ROOT_W        = 25;
   localparam int SREM_W        = 26;
   localparam int DENOM_W       = 31;
   localparam int PROD_W        = ROOT_W + FREQ_W;
   localparam int CSR_IDX_W     = 2;
   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(346000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_X    = 2'd0,
      CSR_TARGET_Y    = 2'd1,
      CSR_TARGET_Z    = 2'd2,
      CSR_SOUND_SPEED = 2'd3
   } csr_index_type;
endpackage

### sv/transducer_focus_phase.sv
// A beat passes input registers, square-root cells, a product register, divider cells, output register.
// Throughput: one transducer per cycle; busy is low whenever reset is low.
// The chain holds 25 square-root cells and 45 + FRAC_BITS divider cells,
// each retiring one bit per cycle.
// Reset (synchronous, active high) clears the pipeline valid bits and the focus registers;
// sound speed resets to 346000 mm/s. The receiver cannot stall.
`timescale 1ns / 1ps
module transducer_focus_phase #(
   parameter int FRAC_BITS = tfp_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [tfp_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [tfp_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [tfp_pkg::COORD_W-1:0]  req_pos_z,
   input  logic [tfp_pkg::FREQ_W-1:0]          req_frequency_hz,
   output logic                                rsp_valid,
   output logic [FRAC_BITS+1:0]                rsp_phase_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tfp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tfp_pkg::COORD_W-1:0]         csr_data
);
   import tfp_pkg::*;

   localparam int NSQ   = ROOT_W;
   localparam int NDIV  = PROD_W + FRAC_BITS;
   localparam int DVD_W = PROD_W + FRAC_BITS;

   logic signed [COORD_W-1:0] tx_ff, ty_ff, tz_ff;
   logic [DENOM_W-1:0]        denom_ff, denom_in;
   logic [SPEED_W-1:0]        speed_val;

   logic                      accept;
   logic                      s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic [ABS_W-1:0]          ax_ff, ay_ff, az_ff;
   logic [FREQ_W-1:0]         f0_ff, f1_ff, f2_ff;
   logic [2*ABS_W-1:0]        sx_ff, sy_ff, sz_ff;
   logic [SUMSQ_W-1:0]        sum_ff;
   logic signed [ABS_W-1:0]   dx, dy, dz;
   logic [2*ABS_W+1:0]        sum_wide;

   logic                      sq_v    [0:NSQ];
   logic [SUMSQ_W-1:0]        sq_n    [0:NSQ];
   logic [SREM_W-1:0]         sq_rem  [0:NSQ];
   logic [ROOT_W-1:0]         sq_root [0:NSQ];
   logic [FREQ_W-1:0]         sq_side [0:NSQ];

   logic                      m_valid_ff;
   logic [PROD_W-1:0]         prod_ff;

   logic                      dv_v   [0:NDIV];
   logic [DVD_W-1:0]          dv_dvd [0:NDIV];
   logic [DENOM_W-1:0]        dv_rem [0:NDIV];
   logic [FRAC_BITS-1:0]      dv_q   [0:NDIV];

   logic                      out_valid_ff;
   logic [FRAC_BITS+1:0]      code_ff;
   logic [FRAC_BITS:0]        one_minus;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      speed_val = csr_data[SPEED_W-1:0];
      if (speed_val == '0) begin
         speed_val = SPEED_W'(1);
      end
      denom_in = DENOM_W'(speed_val) * DENOM_W'(1000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff    <= '0;
         ty_ff    <= '0;
         tz_ff    <= '0;
         denom_ff <= DENOM_W'(SPEED_RESET) * DENOM_W'(1000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_X:    tx_ff <= csr_data;
            CSR_TARGET_Y:    ty_ff <= csr_data;
            CSR_TARGET_Z:    tz_ff <= csr_data;
            CSR_SOUND_SPEED: denom_ff <= denom_in;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      dx = ABS_W'(req_pos_x) - ABS_W'(tx_ff);
      dy = ABS_W'(req_pos_y) - ABS_W'(ty_ff);
      dz = ABS_W'(req_pos_z) - ABS_W'(tz_ff);
      sum_wide = (2*ABS_W+2)'(sx_ff) + (2*ABS_W+2)'(sy_ff) + (2*ABS_W+2)'(sz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      ax_ff  <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
      ay_ff  <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
      az_ff  <= dz[ABS_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
      f0_ff  <= req_frequency_hz;
      sx_ff  <= ax_ff * ax_ff;
      sy_ff  <= ay_ff * ay_ff;
      sz_ff  <= az_ff * az_ff;
      f1_ff  <= f0_ff;
      sum_ff <= sum_wide[SUMSQ_W-1:0];
      f2_ff  <= f1_ff;
   end

   assign sq_v[0]    = s2_valid_ff;
   assign sq_n[0]    = sum_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = f2_ff;

   for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
      tfp_sqrt_cell #(.SIDE_W(FREQ_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[i]),
         .in_n      (sq_n[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_v[i+1]),
         .out_n     (sq_n[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= sq_v[NSQ];
      end
      prod_ff <= sq_root[NSQ] * sq_side[NSQ];
   end

   assign dv_v[0]   = m_valid_ff;
   assign dv_dvd[0] = {prod_ff, FRAC_BITS'(0)};
   assign dv_rem[0] = '0;
   assign dv_q[0]   = '0;

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      tfp_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .denom     (denom_ff),
         .in_valid  (dv_v[j]),
         .in_dvd    (dv_dvd[j]),
         .in_rem    (dv_rem[j]),
         .in_q      (dv_q[j]),
         .out_valid (dv_v[j+1]),
         .out_dvd   (dv_dvd[j+1]),
         .out_rem   (dv_rem[j+1]),
         .out_q     (dv_q[j+1])
      );
   end

   assign one_minus = {1'b1, FRAC_BITS'(0)} - {1'b0, dv_q[NDIV]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_v[NDIV];
      end
      code_ff <= {one_minus, 1'b0};
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_phase_code = code_ff;
endmodule

### sv/tfp_sqrt_cell.sv
`timescale 1ns / 1ps
module tfp_sqrt_cell #(
   parameter int SIDE_W = tfp_pkg::FREQ_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [tfp_pkg::SUMSQ_W-1:0]   in_n,
   input  logic [tfp_pkg::SREM_W-1:0]    in_rem,
   input  logic [tfp_pkg::ROOT_W-1:0]    in_root,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [tfp_pkg::SUMSQ_W-1:0]   out_n,
   output logic [tfp_pkg::SREM_W-1:0]    out_rem,
   output logic [tfp_pkg::ROOT_W-1:0]    out_root,
   output logic [SIDE_W-1:0]             out_side
);
   import tfp_pkg::*;

   logic                  valid_ff;
   logic [SUMSQ_W-1:0]    n_ff, n_in;
   logic [SREM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0]     side_ff;
   logic [SREM_W+1:0]     trial_val;
   logic [SREM_W+1:0]     rem_shift;
   logic [SREM_W+1:0]     diff_val;
   logic                  take;

   always_comb begin
      rem_shift = {in_rem, in_n[SUMSQ_W-1 -: 2]};
      trial_val = {(SREM_W - ROOT_W)'(0), in_root, 2'b01};
      take      = rem_shift >= trial_val;
      diff_val  = rem_shift - trial_val;
      rem_in    = take ? diff_val[SREM_W-1:0] : rem_shift[SREM_W-1:0];
      root_in   = {in_root[ROOT_W-2:0], take};
      n_in      = {in_n[SUMSQ_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule

### sv/tfp_div_cell.sv
`timescale 1ns / 1ps
module tfp_div_cell #(
   parameter int FRAC_BITS = tfp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tfp_pkg::DENOM_W-1:0]       denom,
   input  logic                              in_valid,
   input  logic [tfp_pkg::PROD_W+FRAC_BITS-1:0] in_dvd,
   input  logic [tfp_pkg::DENOM_W-1:0]       in_rem,
   input  logic [FRAC_BITS-1:0]              in_q,
   output logic                              out_valid,
   output logic [tfp_pkg::PROD_W+FRAC_BITS-1:0] out_dvd,
   output logic [tfp_pkg::DENOM_W-1:0]       out_rem,
   output logic [FRAC_BITS-1:0]              out_q
);
   import tfp_pkg::*;

   localparam int DVD_W = PROD_W + FRAC_BITS;

   logic                valid_ff;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [DENOM_W-1:0]  rem_ff, rem_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [DENOM_W:0]    rem_shift;
   logic [DENOM_W:0]    diff_val;
   logic                take;

   always_comb begin
      rem_shift = {in_rem, in_dvd[DVD_W-1]};
      take      = rem_shift >= {1'b0, denom};
      diff_val  = rem_shift - {1'b0, denom};
      rem_in    = take ? diff_val[DENOM_W-1:0] : rem_shift[DENOM_W-1:0];
      q_in      = {in_q[FRAC_BITS-2:0], take};
      dvd_in    = {in_dvd[DVD_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign out_valid = valid_ff;
   assign out_dvd   = dvd_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;
endmodule

### sv/tfp_checker.sv
`timescale 1ns / 1ps
`include "transducer_focus_phase_macros.svh"
module tfp_checker #(
   parameter int FRAC_BITS = tfp_pkg::FRAC_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [FRAC_BITS+1:0] rsp_phase_code,
   input logic                 csr_ready
);
   import tfp_pkg::*;

   localparam int LAT = 5 + ROOT_W + PROD_W + FRAC_BITS;

   `TFP_ASSERT_IMPLY(a_rsp_from_beat, clock, reset, rsp_valid, $past(start && !busy, LAT))
   `TFP_ASSERT_IMPLY(a_code_even, clock, reset, rsp_valid, rsp_phase_code[0] == 1'b0 && rsp_phase_code != '0)
   `TFP_ASSERT_ALWAYS(a_idle_ready, clock, reset, !busy && csr_ready)
endmodule

bind transducer_focus_phase tfp_checker #(.FRAC_BITS(FRAC_BITS)) u_tfp_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_phase_code (rsp_phase_code),
   .csr_ready      (csr_ready)
);

### bench/transducer_focus_phase_tb.sv
`timescale 1ns / 1ps
module transducer_focus_phase_tb;
   import tfp_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = 91;
   localparam int N_RANDOM = 1730;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [FB+1:0] FULL_TURN = 18'(1 << (FB + 1));

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic [FREQ_W-1:0] req_frequency_hz = '0;
   logic rsp_valid;
   logic [FB+1:0] rsp_phase_code;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_data = '0;

   transducer_focus_phase #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_frequency_hz(req_frequency_hz),
      .rsp_valid(rsp_valid), .rsp_phase_code(rsp_phase_code),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   typedef struct {
      logic signed [COORD_W-1:0] px, py, pz;
      logic [FREQ_W-1:0]         freq;
      logic                      typed;
      logic [FB+1:0]             code;
   } beat_row_type;

   logic signed [COORD_W-1:0] focus_x, focus_y, focus_z;
   logic [SPEED_W-1:0] speed_mm_s;
   logic [FB+1:0] phase_queue[$];
   int errors = 0;
   longint cycles = 0;
   bit idle_gaps = 1'b1;

   function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SUMSQ_W+1:0] n);
      logic [63:0] rem, root, bit_w;
      rem = 64'(n);
      root = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w >>= 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem -= root + bit_w;
            root = (root >> 1) + bit_w;
         end else begin
            root >>= 1;
         end
         bit_w >>= 2;
      end
      return ROOT_W'(root);
   endfunction

   function automatic logic [FB+1:0] focus_phase(input logic signed [COORD_W-1:0] px,
         input logic signed [COORD_W-1:0] py, input logic signed [COORD_W-1:0] pz,
         input logic [FREQ_W-1:0] freq);
      longint ax, ay, az;
      logic [63:0] c, denom, path_len, prod, rem, frac;
      ax = longint'(px) - longint'(focus_x);
      ay = longint'(py) - longint'(focus_y);
      az = longint'(pz) - longint'(focus_z);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (az < 0) az = -az;
      c = (speed_mm_s != 0) ? 64'(speed_mm_s) : 64'd1;
      denom = c * 1000;
      path_len = 64'(floor_sqrt(52'(ax * ax + ay * ay + az * az)));
      prod = path_len * 64'(freq);
      rem = prod % denom;
      frac = ((rem << FB) / denom) & ((64'd1 << FB) - 1);
      return (FB + 2)'(2 * ((64'd1 << FB) - frac));
   endfunction

   task automatic report_mismatch(input string what, input logic [FB+1:0] got,
         input logic [FB+1:0] want);
      errors++;
      $display("mismatch %s: phase_code got %0d want %0d at cycle %0d",
               what, got, want, cycles);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (phase_queue.size() == 0) report_mismatch("unexpected beat", rsp_phase_code, '0);
         else begin
            if (rsp_phase_code !== phase_queue[0])
               report_mismatch("phase", rsp_phase_code, phase_queue[0]);
            void'(phase_queue.pop_front());
         end
      end
   end

   task automatic gap();
      int n;
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 7);
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [COORD_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TARGET_X: focus_x = val;
         CSR_TARGET_Y: focus_y = val;
         CSR_TARGET_Z: focus_z = val;
         CSR_SOUND_SPEED: speed_mm_s = val[SPEED_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (phase_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic send(input beat_row_type r);
      logic [FB+1:0] want;
      start <= 1'b1;
      req_pos_x <= r.px;
      req_pos_y <= r.py;
      req_pos_z <= r.pz;
      req_frequency_hz <= r.freq;
      want = focus_phase(r.px, r.py, r.pz, r.freq);
      if (r.typed && want !== r.code) report_mismatch("table row", want, r.code);
      @(posedge clock);
      while (busy) @(posedge clock);
      phase_queue.push_back(r.typed ? r.code : want);
      @(negedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return COORD_W'($urandom_range(0, 2000)) - 24'sd1000;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic beat_row_type rand_row();
      beat_row_type r;
      r.px = rand_coord();
      r.py = rand_coord();
      r.pz = rand_coord();
      r.freq = ($urandom_range(0, 15) == 0) ? FREQ_W'($urandom_range(0, 1))
                                             : FREQ_W'($urandom);
      r.typed = 1'b0;
      r.code = '0;
      return r;
   endfunction

   beat_row_type directed[] = '{
      '{24'sd0, 24'sd0, 24'sd0, 20'd40000, 1'b1, FULL_TURN},
      '{24'sd1000, 24'sd0, 24'sd0, 20'd0, 1'b1, FULL_TURN},
      '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 20'hFFFFF, 1'b0, '0},
      '{24'sh800000, 24'sh800000, 24'sh800000, 20'hFFFFF, 1'b0, '0},
      '{24'sh7FFFFF, 24'sh800000, 24'sd0, 20'd1, 1'b0, '0},
      '{24'sd8650, 24'sd0, 24'sd0, 20'd40000, 1'b0, '0},
      '{-24'sd4325, 24'sd3000, 24'sd77, 20'd40000, 1'b0, '0},
      '{24'sd0, 24'sd0, 24'sd1, 20'd1, 1'b0, '0},
      '{24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 20'h55555, 1'b0, '0},
      '{24'shAAAAAA, 24'sh555555, 24'shF0F0F0, 20'hAAAAA, 1'b0, '0}
   };

   initial begin
      int phase;
      focus_x = 0;
      focus_y = 0;
      focus_z = 0;
      speed_mm_s = SPEED_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         gap();
         send(directed[i]);
      end
      drain();
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(CSR_TARGET_X, 24'h7FFFFF);
               csr_write(CSR_TARGET_Y, 24'h800000);
               csr_write(CSR_TARGET_Z, 24'h7FFFFF);
               csr_write(CSR_SOUND_SPEED, 24'd0);
            end
            1: csr_write(CSR_SOUND_SPEED, 24'h1FFFFF);
            2: begin
               csr_write(CSR_TARGET_X, 24'h800000);
               csr_write(CSR_TARGET_Y, 24'h7FFFFF);
               csr_write(CSR_TARGET_Z, 24'h800000);
               csr_write(CSR_SOUND_SPEED, 24'd100000);
            end
            3: csr_write(CSR_SOUND_SPEED, 24'd2000000);
            4: begin
               csr_write(CSR_TARGET_X, COORD_W'($urandom));
               csr_write(CSR_TARGET_Y, COORD_W'($urandom));
               csr_write(CSR_TARGET_Z, COORD_W'($urandom));
               csr_write(CSR_SOUND_SPEED, 24'($urandom_range(0, 2097151)));
            end
            default: begin
               csr_write(CSR_TARGET_X, 24'd0);
               csr_write(CSR_TARGET_Y, 24'd0);
               csr_write(CSR_TARGET_Z, 24'd0);
               csr_write(CSR_SOUND_SPEED, 24'(SPEED_RESET));
               idle_gaps = 1'b0;
            end
         endcase
         for (int k = 0; k < N_RANDOM / 6; k++) begin
            gap();
            if (k == 100 && phase == 1) begin
               start <= 1'b0;
               while (phase_queue.size() != 0) @(negedge clock);
            end
            send(rand_row());
         end
         drain();
      end
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### files.f
+incdir+sv
sv/tfp_pkg.sv
sv/tfp_sqrt_cell.sv
sv/tfp_div_cell.sv
sv/transducer_focus_phase.sv
sv/tfp_checker.sv
bench/transducer_focus_phase_tb.sv
